// ----- hdl/jdcd_pkg.sv -----
// Shared constants, types and tables for the Julian Day to calendar date converter.
package jdcd_pkg;

   // fixed-point format of the incoming Julian Day
   localparam int FRAC_BITS = 40;
   localparam int DAY_BITS  = 23;
   localparam int JD_W      = DAY_BITS + FRAC_BITS;

   // time of day in units of 2^-FRAC_BITS minute
   localparam int MIN_W = 11;
   localparam int TOD_W = FRAC_BITS + MIN_W;
   localparam int OFS_W = 12;

   localparam logic [MIN_W-1:0] MIN_PER_DAY  = MIN_W'(1440);
   localparam logic [MIN_W-1:0] HALF_DAY_MIN = MIN_W'(720);
   localparam logic [TOD_W:0]   TOD_FULL     = (TOD_W+1)'(MIN_PER_DAY) << FRAC_BITS;

   // day number after the shift, and the Meeus intermediates
   localparam int Z_W  = DAY_BITS + 1;
   localparam int B_W  = Z_W;
   localparam logic [Z_W-1:0] GREG_START = Z_W'(2299161);

   // alpha = (4z - 7468865) / 146097
   localparam int X_W  = DAY_BITS + 2;
   localparam int QA_W = 8;
   localparam logic [X_W-1:0]  ALPHA_BIAS = X_W'(7468865);
   localparam logic [17:0]     ALPHA_DIV  = 18'd146097;
   localparam logic [QA_W-1:0] ALPHA_M    = QA_W'((2**X_W) / 146097);

   // c = (20b - 2442) / 7305
   localparam int Y_W  = DAY_BITS + 5;
   localparam int C_W  = DAY_BITS - 8;
   localparam int MC_W = 16;
   localparam logic [Y_W-1:0]  C_BIAS = Y_W'(2442);
   localparam logic [4:0]      C_MUL  = 5'd20;
   localparam logic [12:0]     C_DIV  = 13'd7305;
   localparam logic [MC_W-1:0] C_M    = MC_W'((2**Y_W) / 7305);
   localparam logic [10:0]     D_MUL  = 11'd1461;
   localparam logic [10:0]     B_BIAS = 11'd1524;

   // e = (b - d) * 10000 / 306001
   localparam int BD_W  = 9;
   localparam int NUM_W = 23;
   localparam int E_W   = 4;
   localparam logic [13:0] E_MUL = 14'd10000;
   localparam logic [18:0] E_DIV = 19'd306001;
   localparam logic [4:0]  E_M   = 5'((2**NUM_W) / 306001);
   localparam logic [18:0] E_NM  = 19'(10000 * ((2**NUM_W) / 306001));

   localparam int YEAR_W = 16;
   localparam logic [YEAR_W-1:0] YEAR_BIAS_EARLY = YEAR_W'(4716);
   localparam logic [YEAR_W-1:0] YEAR_BIAS_LATE  = YEAR_W'(4715);

   // time-of-day split
   localparam int US_W   = 20;
   localparam int HOUR_K = 16;
   localparam logic [MIN_W-1:0] HOUR_M      = MIN_W'(1093);
   localparam logic [5:0]       SEC_PER_MIN = 6'd60;
   localparam logic [US_W-1:0]  US_PER_SEC  = US_W'(1000000);

   typedef struct packed {
      logic [1:0]       day_adj;   // -1, 0 or +1, two's complement
      logic [MIN_W-1:0] rem_min;   // 0..1439
   } jdcd_shift_type;

   typedef struct packed {
      logic [4:0]      hour;
      logic [5:0]      minute;
      logic [5:0]      second;
      logic [US_W-1:0] usec;
   } jdcd_time_type;

   // floor(30.6001 * e)
   function automatic logic [BD_W-1:0] days_before(input logic [E_W-1:0] e_idx);
      logic [BD_W-1:0] v;
      case (e_idx)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd30;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd91;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd183;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd244;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd336;
         4'd12:   v = 9'd367;
         4'd13:   v = 9'd397;
         4'd14:   v = 9'd428;
         4'd15:   v = 9'd459;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/julian_day_to_calendar_date_core.sv -----
// Top level: pipelined fixed-point Julian Day to calendar date and time-of-day converter.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata: jd_fixed
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: date and time, rsp_tuser: status
//  csr      in         csr_valid/csr_ready    csr_wdata: utc_offset_minutes
//
//  One transaction per cycle sustained while rsp_tready is high; one register per pipeline stage.
//  The depth is set by the reciprocal divides (alpha, c, e), each an estimate stage
//  followed by a correction stage.
//  Each stage holds while it is full and the stage after it holds; empty stages fill behind a stall.
//  Synchronous reset clears the valid bits and sets the offset to zero.
module julian_day_to_calendar_date_core
   import jdcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] jd_fixed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
                                    // [35:30] minute, [41:36] second, [61:42] microsecond
   output logic [0:0]  rsp_tuser,   // [0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata    // [11:0] utc_offset_minutes
);

   localparam int NSTG = 11;
   localparam int TW1  = TOD_W + 1;
   localparam int PA_W = X_W + QA_W;
   localparam int PC_W = Y_W + MC_W;
   localparam int PE_W = NUM_W + 5;
   localparam int PU_W = FRAC_BITS + US_W;
   localparam int PH_W = MIN_W + HOUR_K;
   localparam int PS_W = FRAC_BITS + 6;

   jdcd_shift_type shift;

   jdcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata[OFS_W-1:0]),
      .shift     (shift)
   );

   // valid pipeline
   logic [NSTG:1] vld_ff;
   logic [NSTG:1] vld_in;
   logic [NSTG:1] adv;

   assign adv[NSTG] = !vld_ff[NSTG] || rsp_tready;
   for (genvar k = 1; k < NSTG; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   always_comb begin
      vld_in[1] = adv[1] ? req_tvalid : vld_ff[1];
      for (int k = 2; k <= NSTG; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[1];
   assign rsp_tvalid = vld_ff[NSTG];

   // stage 1: split, time-of-day scale and minute shift
   logic [JD_W-1:0]  req_jd;
   logic [TOD_W:0]   s1_tod_in;
   logic             s1_zero_ff;
   logic [DAY_BITS-1:0] s1_z_ff;
   logic [TOD_W:0]   s1_tod_ff;

   assign req_jd    = req_tdata[JD_W-1:0];
   assign s1_tod_in = TW1'(req_jd[FRAC_BITS-1:0]) * TW1'(MIN_PER_DAY) +
                      (TW1'(shift.rem_min) << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_zero_ff <= (req_jd == '0);
         s1_z_ff    <= req_jd[JD_W-1:FRAC_BITS];
         s1_tod_ff  <= s1_tod_in;
      end
   end

   // stage 2: day carry and day number
   logic             s2_carry;
   logic [TOD_W:0]   s2_tod;
   logic [Z_W:0]     s2_zsum;
   logic             s2_bad_ff;
   logic [Z_W-1:0]   s2_z_ff;
   logic [MIN_W-1:0] s2_mod_ff;
   logic [FRAC_BITS-1:0] s2_r_ff;

   assign s2_carry = (s1_tod_ff >= TOD_FULL);
   assign s2_tod   = s2_carry ? (s1_tod_ff - TOD_FULL) : s1_tod_ff;
   assign s2_zsum  = (Z_W+1)'(s1_z_ff) +
                     {{(Z_W-1){shift.day_adj[1]}}, shift.day_adj} +
                     (Z_W+1)'(s2_carry);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_bad_ff <= s1_zero_ff || s2_zsum[Z_W];
         s2_z_ff   <= s2_zsum[Z_W-1:0];
         s2_mod_ff <= s2_tod[TOD_W-1:FRAC_BITS];
         s2_r_ff   <= s2_tod[FRAC_BITS-1:0];
      end
   end

   // stage 3: alpha estimate, seconds, hour
   logic             s3_greg;
   logic [X_W+1:0]   s3_x4;
   logic [X_W-1:0]   s3_x;
   logic [PA_W-1:0]  s3_pa;
   logic [PS_W-1:0]  s3_ps;
   logic [PH_W-1:0]  s3_ph;
   logic             s3_bad_ff;
   logic [Z_W-1:0]   s3_z_ff;
   logic             s3_greg_ff;
   logic [X_W-1:0]   s3_x_ff;
   logic [QA_W-1:0]  s3_qa_ff;
   logic [MIN_W-1:0] s3_mod_ff;
   logic [4:0]       s3_hour_ff;
   logic [5:0]       s3_sec_ff;
   logic [FRAC_BITS-1:0] s3_r2_ff;

   assign s3_greg = (s2_z_ff >= GREG_START);
   assign s3_x4   = (X_W+2)'({s2_z_ff, 2'b00}) - (X_W+2)'(ALPHA_BIAS);
   assign s3_x    = s3_greg ? s3_x4[X_W-1:0] : '0;
   assign s3_pa   = PA_W'(s3_x) * PA_W'(ALPHA_M);
   assign s3_ps   = PS_W'(s2_r_ff) * PS_W'(SEC_PER_MIN);
   assign s3_ph   = PH_W'(s2_mod_ff) * PH_W'(HOUR_M);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_bad_ff  <= s2_bad_ff;
         s3_z_ff    <= s2_z_ff;
         s3_greg_ff <= s3_greg;
         s3_x_ff    <= s3_x;
         s3_qa_ff   <= s3_pa[PA_W-1:X_W];
         s3_mod_ff  <= s2_mod_ff;
         s3_hour_ff <= s3_ph[HOUR_K+4:HOUR_K];
         s3_sec_ff  <= s3_ps[FRAC_BITS+5:FRAC_BITS];
         s3_r2_ff   <= s3_ps[FRAC_BITS-1:0];
      end
   end

   // stage 4: alpha correction, microseconds, minute
   logic [QA_W:0]    s4_qa1;
   logic [X_W+1:0]   s4_chk;
   logic [PU_W-1:0]  s4_pu;
   logic [MIN_W-1:0] s4_min;
   logic             s4_bad_ff;
   logic [Z_W-1:0]   s4_z_ff;
   logic             s4_greg_ff;
   logic [QA_W-1:0]  s4_alpha_ff;
   jdcd_time_type    s4_tm_ff;

   assign s4_qa1 = (QA_W+1)'(s3_qa_ff) + (QA_W+1)'(1);
   assign s4_chk = (X_W+2)'(s4_qa1) * (X_W+2)'(ALPHA_DIV);
   assign s4_pu  = PU_W'(s3_r2_ff) * PU_W'(US_PER_SEC);
   assign s4_min = s3_mod_ff - MIN_W'(s3_hour_ff) * MIN_W'(SEC_PER_MIN);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_bad_ff   <= s3_bad_ff;
         s4_z_ff     <= s3_z_ff;
         s4_greg_ff  <= s3_greg_ff;
         s4_alpha_ff <= (s4_chk <= (X_W+2)'(s3_x_ff)) ? s4_qa1[QA_W-1:0] : s3_qa_ff;
         s4_tm_ff    <= '{hour:   s3_hour_ff,
                          minute: s4_min[5:0],
                          second: s3_sec_ff,
                          usec:   s4_pu[PU_W-1:FRAC_BITS]};
      end
   end

   // stage 5: b = a + 1524
   logic [B_W-1:0] s5_adj;
   logic           s5_bad_ff;
   logic [B_W-1:0] s5_b_ff;
   jdcd_time_type  s5_tm_ff;

   assign s5_adj = s4_greg_ff ?
                   (B_W'(s4_alpha_ff) - B_W'(s4_alpha_ff[QA_W-1:2]) + B_W'(1)) : '0;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_bad_ff <= s4_bad_ff;
         s5_b_ff   <= s4_z_ff + s5_adj + B_W'(B_BIAS);
         s5_tm_ff  <= s4_tm_ff;
      end
   end

   // stage 6: c estimate
   logic [Y_W-1:0]  s6_y;
   logic [PC_W-1:0] s6_pc;
   logic            s6_bad_ff;
   logic [B_W-1:0]  s6_b_ff;
   logic [Y_W-1:0]  s6_y_ff;
   logic [C_W-1:0]  s6_qc_ff;
   jdcd_time_type   s6_tm_ff;

   assign s6_y  = Y_W'(s5_b_ff) * Y_W'(C_MUL) - C_BIAS;
   assign s6_pc = PC_W'(s6_y) * PC_W'(C_M);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_bad_ff <= s5_bad_ff;
         s6_b_ff   <= s5_b_ff;
         s6_y_ff   <= s6_y;
         s6_qc_ff  <= s6_pc[Y_W+C_W-1:Y_W];
         s6_tm_ff  <= s5_tm_ff;
      end
   end

   // stage 7: c correction
   logic [C_W:0]   s7_qc1;
   logic [Y_W+1:0] s7_chk;
   logic           s7_bad_ff;
   logic [B_W-1:0] s7_b_ff;
   logic [C_W-1:0] s7_c_ff;
   jdcd_time_type  s7_tm_ff;

   assign s7_qc1 = (C_W+1)'(s6_qc_ff) + (C_W+1)'(1);
   assign s7_chk = (Y_W+2)'(s7_qc1) * (Y_W+2)'(C_DIV);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_bad_ff <= s6_bad_ff;
         s7_b_ff   <= s6_b_ff;
         s7_c_ff   <= (s7_chk <= (Y_W+2)'(s6_y_ff)) ? s7_qc1[C_W-1:0] : s6_qc_ff;
         s7_tm_ff  <= s6_tm_ff;
      end
   end

   // stage 8: b - floor(365.25 c)
   logic [C_W+10:0] s8_pd;
   logic [B_W-1:0]  s8_bd;
   logic            s8_bad_ff;
   logic [C_W-1:0]  s8_c_ff;
   logic [BD_W-1:0] s8_bd_ff;
   jdcd_time_type   s8_tm_ff;

   assign s8_pd = (C_W+11)'(s7_c_ff) * (C_W+11)'(D_MUL);
   assign s8_bd = s7_b_ff - s8_pd[C_W+10:2];

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_bad_ff <= s7_bad_ff;
         s8_c_ff   <= s7_c_ff;
         s8_bd_ff  <= s8_bd[BD_W-1:0];
         s8_tm_ff  <= s7_tm_ff;
      end
   end

   // stage 9: e estimate
   logic [PE_W-1:0]  s9_pe;
   logic             s9_bad_ff;
   logic [C_W-1:0]   s9_c_ff;
   logic [BD_W-1:0]  s9_bd_ff;
   logic [NUM_W-1:0] s9_num_ff;
   logic [E_W-1:0]   s9_qe_ff;
   jdcd_time_type    s9_tm_ff;

   assign s9_pe = PE_W'(s8_bd_ff) * PE_W'(E_NM);

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s9_bad_ff <= s8_bad_ff;
         s9_c_ff   <= s8_c_ff;
         s9_bd_ff  <= s8_bd_ff;
         s9_num_ff <= NUM_W'(s8_bd_ff) * NUM_W'(E_MUL);
         s9_qe_ff  <= s9_pe[NUM_W+E_W-1:NUM_W];
         s9_tm_ff  <= s8_tm_ff;
      end
   end

   // stage 10: e correction
   logic [E_W:0]     s10_qe1;
   logic [NUM_W:0]   s10_chk;
   logic             s10_bad_ff;
   logic [C_W-1:0]   s10_c_ff;
   logic [BD_W-1:0]  s10_bd_ff;
   logic [E_W-1:0]   s10_e_ff;
   jdcd_time_type    s10_tm_ff;

   assign s10_qe1 = (E_W+1)'(s9_qe_ff) + (E_W+1)'(1);
   assign s10_chk = (NUM_W+1)'(s10_qe1) * (NUM_W+1)'(E_DIV);

   always_ff @(posedge clock) begin
      if (adv[10]) begin
         s10_bad_ff <= s9_bad_ff;
         s10_c_ff   <= s9_c_ff;
         s10_bd_ff  <= s9_bd_ff;
         s10_e_ff   <= (s10_chk <= (NUM_W+1)'(s9_num_ff)) ? s10_qe1[E_W-1:0] : s9_qe_ff;
         s10_tm_ff  <= s9_tm_ff;
      end
   end

   // stage 11: day, month, year and output register
   logic [BD_W-1:0]   s11_day;
   logic [E_W-1:0]    s11_month;
   logic [YEAR_W-1:0] s11_year;
   logic [63:0]       rsp_data_in;
   logic [63:0]       rsp_data_ff;
   logic              rsp_status_ff;

   assign s11_day   = s10_bd_ff - days_before(s10_e_ff);
   assign s11_month = (s10_e_ff < 4'd14) ? (s10_e_ff - 4'd1) : (s10_e_ff - 4'd13);
   assign s11_year  = YEAR_W'(s10_c_ff) -
                      ((s11_month > 4'd2) ? YEAR_BIAS_EARLY : YEAR_BIAS_LATE);

   always_comb begin
      if (s10_bad_ff) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = {2'b00, s10_tm_ff.usec, s10_tm_ff.second, s10_tm_ff.minute,
                        s10_tm_ff.hour, s11_day[4:0], s11_month, s11_year};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         rsp_status_ff <= s10_bad_ff;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;

`ifndef SYNTH
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff) && !rsp_tready)
      else $error("input stalled with a bubble in the pipeline");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("invalid transaction carries nonzero fields");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[19:16] != 4'd0 && rsp_tdata[19:16] <= 4'd12 && rsp_tdata[24:20] != 5'd0)
      else $error("month or day out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:25] <= 5'd23 && rsp_tdata[35:30] <= 6'd59 &&
                     rsp_tdata[41:36] <= 6'd59 && rsp_tdata[61:42] <= 20'd999999)
      else $error("time of day field out of range");
`endif

endmodule

// ----- hdl/jdcd_csr.sv -----
// UTC offset register, held as a whole-day adjust and a minute remainder of the half-day shift.
module jdcd_csr
   import jdcd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [OFS_W-1:0] csr_wdata,
   output jdcd_shift_type   shift
);

   logic signed [OFS_W:0] sum_min;
   logic [OFS_W:0]        wrap_up;
   logic [OFS_W:0]        wrap_dn;
   jdcd_shift_type        shift_in;
   jdcd_shift_type        shift_ff;

   assign csr_ready = 1'b1;
   assign sum_min   = $signed({csr_wdata[OFS_W-1], csr_wdata}) +
                      $signed((OFS_W+1)'(HALF_DAY_MIN));
   assign wrap_up   = $unsigned(sum_min) + (OFS_W+1)'(MIN_PER_DAY);
   assign wrap_dn   = $unsigned(sum_min) - (OFS_W+1)'(MIN_PER_DAY);

   always_comb begin
      if (sum_min[OFS_W]) begin
         shift_in.day_adj = 2'b11;
         shift_in.rem_min = wrap_up[MIN_W-1:0];
      end else if (sum_min[OFS_W-1:0] >= OFS_W'(MIN_PER_DAY)) begin
         shift_in.day_adj = 2'b01;
         shift_in.rem_min = wrap_dn[MIN_W-1:0];
      end else begin
         shift_in.day_adj = 2'b00;
         shift_in.rem_min = sum_min[MIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff.day_adj <= 2'b00;
         shift_ff.rem_min <= HALF_DAY_MIN;
      end else if (csr_valid && csr_ready) begin
         shift_ff <= shift_in;
      end
   end

   assign shift = shift_ff;

endmodule
